// File: rtl/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared constants, codes and types of the frame sync decider.
// ----------------------------------------------------------------------------
package fsd_pkg;

  localparam int MAX_UNIVERSES = 16;
  localparam int IDX_W = (MAX_UNIVERSES > 1) ? $clog2(MAX_UNIVERSES) : 1;
  localparam int CNT_W = $clog2(MAX_UNIVERSES + 1);

  localparam int UNI_W    = 15;
  localparam int COUNT_W  = 5;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;

  localparam logic [TIME_W-1:0] PREV_SPAN_RESET = 32'h00FF_FFFF;

  localparam logic [STATUS_W-1:0] ST_WAIT         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL_SENT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL_DROPPED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PARTIAL_SENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED      = 3'd4;

  localparam logic REG_FIRST_UNIVERSE = 1'b0;
  localparam logic REG_UNIVERSE_COUNT = 1'b1;

  typedef struct packed {
    logic [UNI_W-1:0]   first_universe;
    logic [COUNT_W-1:0] universe_count;
  } fsd_cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   frame_span;
  } fsd_res_t;

endpackage

// File: rtl/frame_sync_decider.sv
// ----------------------------------------------------------------------------
// frame_sync_decider
// Per-packet frame send decision over a RAM of universe arrival times.
// ----------------------------------------------------------------------------
// An in-range universe passes the SCAN, DRAIN and DECIDE states, the scan
// reading N stored times, N being the clamped universe count; an ignored
// one goes straight to DECIDE. The scan reads one stored arrival time per
// cycle from the single RAM port; no new input is taken before DECIDE ends.
// Reset: synchronous; clears flags, valid bits, last output time and first
// universe; previous span to 0xFFFFFF, count to 1; RAM needs no clearing.
module frame_sync_decider (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // universe[14:0], now_us[46:15], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[2:0], frame_span[34:3], zero pad
);

  fsd_pkg::fsd_cfg_t cfg;
  fsd_pkg::fsd_res_t res;
  logic              res_valid;
  logic              res_ready;

  assign cfg_ready = 1'b1;
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_universe <= '0;
      cfg.universe_count <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fsd_pkg::REG_FIRST_UNIVERSE: cfg.first_universe <= cfg_data;
        fsd_pkg::REG_UNIVERSE_COUNT: cfg.universe_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  fsd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_universe(s_tdata[14:0]),
    .in_now     (s_tdata[46:15]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // hold result until the downstream transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {5'd0, res.frame_span, res.status};
    end
  end

endmodule

// File: rtl/fsd_ram.sv
// ----------------------------------------------------------------------------
// fsd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fsd_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [ADDR_W-1:0]       wr_addr,
  input  logic [WIDTH-1:0]        wr_data,
  input  logic [ADDR_W-1:0]       rd_addr,
  output logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/fsd_ctrl.sv
// ----------------------------------------------------------------------------
// fsd_ctrl
// Arrival store, span scan over the time RAM and the frame decision.
// ----------------------------------------------------------------------------
module fsd_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  fsd_pkg::fsd_cfg_t            cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fsd_pkg::UNI_W-1:0]    in_universe,
  input  logic [fsd_pkg::TIME_W-1:0]   in_now,
  output logic                         res_valid,
  input  logic                         res_ready,
  output fsd_pkg::fsd_res_t            res
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  localparam int IDX_W  = fsd_pkg::IDX_W;
  localparam int CNT_W  = fsd_pkg::CNT_W;
  localparam int TIME_W = fsd_pkg::TIME_W;
  localparam int MAXU   = fsd_pkg::MAX_UNIVERSES;

  logic [1:0]              state;
  logic [CNT_W-1:0]        eff;
  logic [CNT_W-1:0]        cnt;
  logic                    ignored;
  logic [TIME_W-1:0]       now;
  logic [TIME_W-1:0]       span;
  logic [TIME_W-1:0]       three_prev;
  logic [TIME_W-1:0]       ten_prev;
  logic [TIME_W-1:0]       elapsed;
  logic [TIME_W-1:0]       prev_span;
  logic [TIME_W-1:0]       last_out;
  logic [MAXU-1:0]         arrived;
  logic [MAXU-1:0]         written;
  logic                    rd_valid;
  logic [IDX_W-1:0]        rd_idx;

  logic [CNT_W-1:0]        eff_next;
  logic [fsd_pkg::UNI_W-1:0] offset;
  logic                    hit;
  logic [IDX_W-1:0]        wr_idx;
  logic                    accept;
  logic                    fire;
  logic [TIME_W-1:0]       rd_data;
  logic [TIME_W-1:0]       stored;
  logic [TIME_W-1:0]       diff;
  logic [MAXU-1:0]         mask;
  logic                    all_in;
  logic [TIME_W-1:0]       span3;
  logic                    close;
  logic [fsd_pkg::STATUS_W-1:0] status;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign res_valid = (state == S_DECIDE);
  assign fire     = res_valid && res_ready;

  always_comb begin
    if ({{(32 - fsd_pkg::COUNT_W){1'b0}}, cfg.universe_count} > 32'(MAXU)) begin
      eff_next = CNT_W'(MAXU);
    end else begin
      eff_next = CNT_W'(cfg.universe_count);
    end
    offset = in_universe - cfg.first_universe;
    hit    = (in_universe >= cfg.first_universe) &&
             ({{(32 - fsd_pkg::UNI_W){1'b0}}, offset} < 32'(eff_next));
    wr_idx = offset[IDX_W-1:0];
  end

  fsd_ram #(
    .WIDTH(TIME_W),
    .DEPTH(MAXU)
  ) u_times (
    .clk    (clk),
    .wr_en  (accept && hit),
    .wr_addr(wr_idx),
    .wr_data(in_now),
    .rd_addr(cnt[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  assign stored = written[rd_idx] ? rd_data : '0;
  assign diff   = now - stored;

  always_comb begin
    for (int i = 0; i < MAXU; i++) begin
      mask[i] = (32'(i) < 32'(eff));
    end
    all_in = &(arrived | ~mask);
    span3  = span + {span[TIME_W-2:0], 1'b0};
    close  = 1'b0;
    status = fsd_pkg::ST_WAIT;
    if (ignored) begin
      status = fsd_pkg::ST_IGNORED;
    end else if (all_in) begin
      close = 1'b1;
      if (span < three_prev || elapsed > ten_prev) begin
        status = fsd_pkg::ST_FULL_SENT;
      end else begin
        status = fsd_pkg::ST_FULL_DROPPED;
      end
    end else if (span3 < prev_span) begin
      close  = 1'b1;
      status = fsd_pkg::ST_PARTIAL_SENT;
    end
    res.status     = status;
    res.frame_span = ignored ? '0 : span;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      arrived   <= '0;
      written   <= '0;
      rd_valid  <= 1'b0;
      prev_span <= fsd_pkg::PREV_SPAN_RESET;
      last_out  <= '0;
    end else begin
      rd_valid <= (state == S_SCAN);
      rd_idx   <= cnt[IDX_W-1:0];
      if (rd_valid && diff > span) begin
        span <= diff;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            now        <= in_now;
            eff        <= eff_next;
            cnt        <= '0;
            span       <= '0;
            ignored    <= !hit;
            three_prev <= prev_span + {prev_span[TIME_W-2:0], 1'b0};
            ten_prev   <= {prev_span[TIME_W-4:0], 3'b000} + {prev_span[TIME_W-2:0], 1'b0};
            elapsed    <= in_now - last_out;
            if (hit) begin
              arrived[wr_idx] <= 1'b1;
              written[wr_idx] <= 1'b1;
              state           <= S_SCAN;
            end else begin
              state <= S_DECIDE;
            end
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == eff - 1'b1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (fire) begin
            state <= S_IDLE;
            if (close) begin
              arrived   <= '0;
              prev_span <= span;
              last_out  <= now;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/fsd_checker.sv
// ----------------------------------------------------------------------------
// fsd_checker
// Port-level checks of the frame sync decider, bound to the top level.
// ----------------------------------------------------------------------------
module fsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while item in progress");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= fsd_pkg::ST_IGNORED)
    else $error("undefined status code");

  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == fsd_pkg::ST_IGNORED |-> m_tdata[34:3] == 32'd0)
    else $error("ignored universe with nonzero span");

endmodule

bind frame_sync_decider fsd_checker u_fsd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
